// ===== hdl/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   // request payload
   typedef struct packed {
      logic     op;
      byte_type byte_value;
   } req_type;

   // response payload
   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } rsp_type;

   localparam logic OpPush   = 1'b0;
   localparam logic OpFinish = 1'b1;

   localparam byte_type PadByte = 8'h80;

   // controller to datapath commands
   typedef struct packed {
      logic       buf_write;     // write buffer entry
      logic [5:0] buf_addr;
      byte_type   buf_data;
      logic       block_start;   // load working vars from chain
      logic       round_step;    // perform one round
      logic [5:0] round_idx;
      logic       block_end;     // fold working vars into chain
      logic       chain_init;    // restore initial values
      logic       out_shift;     // rotate chain for digest output
   } cmd_type;

   typedef struct packed {
      word_type out_word;
   } sts_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage
`default_nettype wire

// ===== hdl/sha_stream_if.sv =====
`default_nettype none
interface sha_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha_datapath.sv =====
`default_nettype none
module sha_datapath (
   input  wire                  clock,
   input  wire sha_pkg::cmd_type cmd,
   output sha_pkg::sts_type     sts
);
   sha_pkg::word_type chain_ff [8];
   sha_pkg::word_type work_ff [8];
   sha_pkg::word_type sched_ff [16];
   sha_pkg::word_type buf_mem [16];
   sha_pkg::word_type rd_word_ff;

   sha_pkg::word_type w_cur, s0, s1, w_new, big0, big1, chs, mj, t1, t2;
   sha_pkg::word_type w15, w2;

   // block buffer: byte lane writes, one word read for the message schedule
   always_ff @(posedge clock) begin
      if (cmd.buf_write) begin
         buf_mem[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'd0} +: 8] <= cmd.buf_data;
      end
      rd_word_ff <= buf_mem[cmd.round_idx[3:0]];
   end

   // message schedule word and round terms for this round
   always_comb begin
      w15   = sched_ff[1];
      w2    = sched_ff[14];
      s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
      s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
      w_new = s1 + sched_ff[9] + s0 + sched_ff[0];
      w_cur = cmd.round_idx[5:4] == 2'd0 ? rd_word_ff : w_new;
      big1  = {work_ff[4][5:0], work_ff[4][31:6]} ^ {work_ff[4][10:0], work_ff[4][31:11]}
            ^ {work_ff[4][24:0], work_ff[4][31:25]};
      chs   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1    = work_ff[7] + big1 + chs + sha_pkg::RoundK[cmd.round_idx] + w_cur;
      big0  = {work_ff[0][1:0], work_ff[0][31:2]} ^ {work_ff[0][12:0], work_ff[0][31:13]}
            ^ {work_ff[0][21:0], work_ff[0][31:22]};
      mj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t2    = big0 + mj;
   end

   // initialise, fold and rotate the chain; load working vars and advance rounds
   always_ff @(posedge clock) begin
      if (cmd.chain_init) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha_pkg::InitHash[i];
      end else if (cmd.block_end) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
      end else if (cmd.out_shift) begin
         for (int i = 0; i < 7; i++) chain_ff[i] <= chain_ff[i+1];
         chain_ff[7] <= chain_ff[0];
      end
      if (cmd.block_start) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
      end else if (cmd.round_step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_cur;
      end
   end

   assign sts.out_word = chain_ff[0];
endmodule
`default_nettype wire

// ===== hdl/sha_control.sv =====
`default_nettype none
module sha_control (
   input  wire               clock,
   input  wire               reset,
   sha_stream_if.sink        req,
   sha_stream_if.source      rsp,
   output sha_pkg::cmd_type  cmd,
   input  wire sha_pkg::sts_type sts
);
   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StPad   = 4'd1;
   localparam logic [3:0] StLen   = 4'd2;
   localparam logic [3:0] StStart = 4'd3;
   localparam logic [3:0] StPrime = 4'd4;
   localparam logic [3:0] StRound = 4'd5;
   localparam logic [3:0] StFold  = 4'd6;
   localparam logic [3:0] StOut   = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] total_ff, total_in;
   logic [5:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;   // finishing message
   logic        last_ff, last_in; // block in flight is the final one
   logic [2:0]  oidx_ff, oidx_in;

   assign req.ready   = state_ff == StIdle;
   assign rsp.valid   = state_ff == StOut;
   assign rsp.payload = {sts.out_word, oidx_ff, oidx_ff == 3'd7};

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      oidx_in  = oidx_ff;
      cmd      = '0;
      cmd.round_idx = idx_ff;
      unique case (state_ff)
         StIdle: begin
            if (req.valid) begin
               if (req.payload.op == sha_pkg::OpPush) begin
                  cmd.buf_write = 1'b1;
                  cmd.buf_addr  = fill_ff;
                  cmd.buf_data  = req.payload.byte_value;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     bits_in  = bits_ff + 64'd512;
                     last_in  = 1'b0;
                     fin_in   = 1'b0;
                     state_in = StStart;
                  end
               end else begin
                  cmd.buf_write = 1'b1;
                  cmd.buf_addr  = fill_ff;
                  cmd.buf_data  = sha_pkg::PadByte;
                  total_in = bits_ff + {55'd0, fill_ff, 3'd0};
                  fin_in   = 1'b1;
                  idx_in   = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     last_in = 1'b0; state_in = StStart;
                  end else begin
                     last_in = fill_ff < 6'd56 ? 1'b1 : 1'b0;
                     state_in = StPad;
                  end
               end
            end
         end
         // zero fill up to the length field, or to block end
         StPad: begin
            if (last_ff && idx_ff >= 6'd56) begin
               idx_in = 6'd56; state_in = StLen;
            end else begin
               cmd.buf_write = 1'b1;
               cmd.buf_addr  = idx_ff;
               cmd.buf_data  = '0;
               idx_in = idx_ff + 6'd1;
               if (idx_ff == 6'd63) state_in = StStart;
            end
         end
         // big-endian length bytes
         StLen: begin
            cmd.buf_write = 1'b1;
            cmd.buf_addr  = idx_ff;
            cmd.buf_data  = total_ff[8*(7-idx_ff[2:0]) +: 8];
            idx_in = idx_ff + 6'd1;
            if (idx_ff == 6'd63) state_in = StStart;
         end
         StStart: begin
            cmd.block_start = 1'b1;
            idx_in = '0;
            state_in = StPrime;
         end
         // buffer word read latency
         StPrime: begin
            cmd.round_idx = idx_ff;
            state_in = StRound;
         end
         StRound: begin
            cmd.round_step = 1'b1;
            cmd.round_idx  = idx_ff;
            idx_in = idx_ff + 6'd1;
            if (idx_ff == 6'd63) state_in = StFold;
            else if (idx_ff < 6'd15) state_in = StPrime;
         end
         StFold: begin
            cmd.block_end = 1'b1;
            if (!fin_ff) state_in = StIdle;
            else if (last_ff) begin
               oidx_in = '0; state_in = StOut;
            end else begin
               last_in = 1'b1; idx_in = '0; state_in = StPad;
            end
         end
         StOut: begin
            if (rsp.ready) begin
               cmd.out_shift = 1'b1;
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  cmd.out_shift  = 1'b0;
                  cmd.chain_init = 1'b1;
                  fill_in = '0; bits_in = '0; fin_in = 1'b0;
                  state_in = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fill_ff  <= '0;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         oidx_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         oidx_ff  <= oidx_in;
         idx_ff   <= idx_in;
      end
      total_ff <= total_in;
   end
endmodule
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher.sv =====
`default_nettype none
// Push: a byte is taken while idle; the 64th byte adds a block pass
// (one round per cycle, but each of the first 16 rounds waits on the buffer read).
// Finish: padding writes before each of one or two block passes, then
// eight digest words, one per cycle while rsp_ready is high.
// Synchronous active-high reset restores the initial chain and zero length.
module sha256_byte_stream_hasher (
   input  wire  clock,
   input  wire  reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   sha_pkg::cmd_type cmd;
   sha_pkg::sts_type sts;

   sha_control u_ctrl (.clock, .reset, .req, .rsp, .cmd, .sts);

   // chain loads its initial values on reset
   sha_pkg::cmd_type dp_cmd;
   always_comb begin
      dp_cmd = cmd;
      if (reset) dp_cmd.chain_init = 1'b1;
   end

   sha_datapath u_dp (.clock, .cmd(dp_cmd), .sts);
endmodule
`default_nettype wire

// ===== hdl/sha_checker.sv =====
`default_nettype none
module sha_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_index,
   input wire        rsp_last
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == 3'd7))) else $error("last flag");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("overlap");
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid) else $error("gap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_index)) else $error("hold");
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_index(rsp.payload.word_index), .rsp_last(rsp.payload.last_word));
`default_nettype wire

// ===== bench/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 100ps
module tb_sha256_byte_stream_hasher;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha_stream_if #(.payload_type(sha_pkg::req_type)) req_ch ();
   sha_stream_if #(.payload_type(sha_pkg::rsp_type)) rsp_ch ();

   sha256_byte_stream_hasher uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // predictor state
   sha_pkg::word_type chain [8];
   sha_pkg::byte_type block_bytes [64];
   int unsigned fill_count;
   logic [63:0] length_bits;

   sha_pkg::rsp_type digest_queue [$];
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   function automatic sha_pkg::word_type ror(sha_pkg::word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      sha_pkg::word_type w [64];
      sha_pkg::word_type v [8];
      sha_pkg::word_type s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int k = 7; k > 0; k--) v[k] = v[k-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
   endtask

   task automatic restart_hash();
      chain = sha_pkg::InitHash;
      fill_count = 0;
      length_bits = '0;
   endtask

   // advance the predictor by one accepted transfer
   task automatic predict_digest(sha_pkg::req_type item);
      logic [63:0] total;
      int unsigned i;
      sha_pkg::rsp_type word_out;
      if (item.op == sha_pkg::OpPush) begin
         block_bytes[fill_count] = item.byte_value;
         fill_count++;
         if (fill_count == 64) begin
            compress_block();
            length_bits += 64'd512;
            fill_count = 0;
         end
      end else begin
         total = length_bits + 64'(fill_count * 8);
         i = fill_count;
         block_bytes[i] = sha_pkg::PadByte;
         i++;
         if (fill_count >= 56) begin
            while (i < 64) begin block_bytes[i] = '0; i++; end
            compress_block();
            i = 0;
         end
         while (i < 56) begin block_bytes[i] = '0; i++; end
         for (int k = 0; k < 8; k++) block_bytes[63-k] = total[8*k +: 8];
         compress_block();
         for (int k = 0; k < 8; k++) begin
            word_out.digest_word = chain[k];
            word_out.word_index = 3'(k);
            word_out.last_word = (k == 7);
            digest_queue = {digest_queue, word_out};
         end
         restart_hash();
      end
   endtask

   // send one transfer and predict at acceptance
   task automatic send_item(logic op, sha_pkg::byte_type value);
      sha_pkg::req_type item;
      item.op = op;
      item.byte_value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      // ready is stable between edges, so sample it mid cycle
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      predict_digest(item);
   endtask

   task automatic push_bytes(int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         send_item(sha_pkg::OpPush, sha_pkg::byte_type'($urandom));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check each digest word
   always @(posedge clock) begin
      sha_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_ch.payload);
            error_count++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_ch.payload.digest_word !== want.digest_word) begin
               $display("%0t: digest_word expected %h actual %h", $time,
                        want.digest_word, rsp_ch.payload.digest_word);
               error_count++;
            end
            if (rsp_ch.payload.word_index !== want.word_index) begin
               $display("%0t: word_index expected %0d actual %0d", $time,
                        want.word_index, rsp_ch.payload.word_index);
               error_count++;
            end
            if (rsp_ch.payload.last_word !== want.last_word) begin
               $display("%0t: last_word expected %0d actual %0d", $time,
                        want.last_word, rsp_ch.payload.last_word);
               error_count++;
            end
         end
      end
   end

   // empty message, extreme bytes, short messages
   task automatic test_directed();
      send_item(sha_pkg::OpFinish, 8'hff);
      send_item(sha_pkg::OpPush, 8'h00);
      send_item(sha_pkg::OpPush, 8'hff);
      send_item(sha_pkg::OpPush, 8'h55);
      send_item(sha_pkg::OpPush, 8'haa);
      send_item(sha_pkg::OpFinish, 8'h00);
      send_item(sha_pkg::OpPush, 8'h61);
      send_item(sha_pkg::OpPush, 8'h62);
      send_item(sha_pkg::OpPush, 8'h63);
      send_item(sha_pkg::OpFinish, 8'h00);
   endtask

   // a whole block, then a tail that forces the extra pad block
   task automatic test_boundaries();
      push_bytes(64 + 56);
      send_item(sha_pkg::OpFinish, 8'h00);
   endtask

   // random short messages
   task automatic test_random(int unsigned budget);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < budget) begin
         len = $urandom_range(12);
         push_bytes(len);
         send_item(sha_pkg::OpFinish, sha_pkg::byte_type'($urandom));
         sent += len + 1;
      end
   endtask

   // hold the sender until all digests are out
   task automatic test_pause();
      push_bytes(5);
      send_item(sha_pkg::OpFinish, 8'h00);
      wait_drained();
      send_item(sha_pkg::OpFinish, 8'h00);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      restart_hash();
      for (int k = 0; k < 64; k++) block_bytes[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 31; recv_idle_pct = 88;
      test_directed();
      test_boundaries();
      test_pause();
      test_random(10);
      send_idle_pct = 88; recv_idle_pct = 31;
      test_random(10);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(10);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

endmodule
